FILE: rtl/chtbl_pkg.sv
// shared types and constants for the chained hash table
`default_nettype none

package chtbl_pkg;

	localparam int FUNC_BITS = 2;
	localparam int IDX_BITS  = 6;

	typedef enum logic [FUNC_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mod_step;
		logic sweep;
		logic head_rd;
		logic ins_commit;
		logic link_sel_next;
		logic node_rd;
		logic hit;
		logic res_full;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_done;
		logic sweep_last;
		logic pool_full;
		logic is_insert;
		logic link_ok;
		logic key_hit;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/chtbl_req_if.sv
// request channel: operation and key
`default_nettype none

interface chtbl_req_if #(
	parameter int KEY_BITS = 16
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, func, key, input ready);
	modport sink (input valid, func, key, output ready);
endinterface

`default_nettype wire

FILE: rtl/chtbl_rsp_if.sv
// response channel: search hit, node index and status
`default_nettype none

interface chtbl_rsp_if ();
	logic       valid;
	logic       ready;
	logic       found;
	logic [5:0] node_index;
	logic       status;

	modport source (output valid, found, node_index, status, input ready);
	modport sink (input valid, found, node_index, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/chained_hash_table.sv
// top level: hash table with separate chaining over a fixed node pool
// one word in flight; the next request word is taken once the result sits in the output register
// insert: hash (reciprocal multiply, multiply back, subtract), head read, commit unless full
// search: hash, head read, then one node memory read per chain node visited
// clear: one bucket head written per cycle; unused codes go straight to the result
// reset: the same bucket sweep runs with ready low, the pool count starts at 0
`default_nettype none

module chained_hash_table #(
	parameter int BUCKETS    = 101,
	parameter int POOL_NODES = 64,
	parameter int KEY_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	chtbl_req_if.sink    req,
	chtbl_rsp_if.source  rsp
);
	import chtbl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready;

	assign req.ready = ready;

	chtbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	chtbl_dp #(
		.BUCKETS    (BUCKETS),
		.POOL_NODES (POOL_NODES),
		.KEY_BITS   (KEY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_func       (req.func),
		.req_key        (req.key),
		.cmd            (cmd),
		.stat           (stat),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_found      (rsp.found),
		.rsp_node_index (rsp.node_index),
		.rsp_status     (rsp.status)
	);

endmodule

`default_nettype wire

FILE: rtl/chtbl_dp.sv
// datapath: bucket hash, bucket head and node memories, chain walk, response register
`default_nettype none

module chtbl_dp #(
	parameter int BUCKETS    = 101,
	parameter int POOL_NODES = 64,
	parameter int KEY_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [chtbl_pkg::FUNC_BITS-1:0]    req_func,
	input  logic [KEY_BITS-1:0]                req_key,
	input  chtbl_pkg::dp_cmd_t                 cmd,
	output chtbl_pkg::dp_stat_t                stat,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic                               rsp_found,
	output logic [chtbl_pkg::IDX_BITS-1:0]     rsp_node_index,
	output logic                               rsp_status
);
	import chtbl_pkg::*;

	localparam int BKT_AW    = $clog2(BUCKETS);
	localparam int POOL_AW   = $clog2(POOL_NODES);
	localparam int LINK_W    = $clog2(POOL_NODES + 1);
	localparam int MOD_STEPS = 3;
	localparam int MOD_CW    = $clog2(MOD_STEPS);
	localparam int MUL_SH    = KEY_BITS + BKT_AW;
	localparam int RECIP_W   = KEY_BITS + 1;
	localparam int PROD_W    = KEY_BITS + RECIP_W;

	localparam logic [63:0] RECIP_FULL =
		((64'd1 << MUL_SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS);

	localparam logic [BKT_AW:0]    BKT_C     = (BKT_AW + 1)'(BUCKETS);
	localparam logic [BKT_AW-1:0]  BKT_LAST  = BKT_AW'(BUCKETS - 1);
	localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(POOL_NODES);
	localparam logic [MOD_CW-1:0]  MOD_LAST  = MOD_CW'(MOD_STEPS - 1);
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_FULL);

	// request and hash state
	logic [FUNC_BITS-1:0] func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [PROD_W-1:0]    prod_q;
	logic [KEY_BITS-1:0]  qd_q;
	logic [BKT_AW-1:0]    rem_q;
	logic [MOD_CW-1:0]    mod_cnt_q;

	// table state
	logic [BKT_AW-1:0]    sweep_q;
	logic [LINK_W-1:0]    nodes_used_q;
	logic [LINK_W-1:0]    steps_q;
	logic [POOL_AW-1:0]   cur_q;

	// memories and their read registers
	logic [LINK_W-1:0]    bucket_mem [BUCKETS];
	logic [KEY_BITS-1:0]  key_mem [POOL_NODES];
	logic [LINK_W-1:0]    next_mem [POOL_NODES];
	logic [LINK_W-1:0]    head_q;
	logic [KEY_BITS-1:0]  nkey_q;
	logic [LINK_W-1:0]    nnext_q;

	// staged result and output word
	logic                 res_found_q;
	logic [IDX_BITS-1:0]  res_index_q;
	logic                 res_status_q;
	logic                 out_valid_q;
	logic                 out_found_q;
	logic [IDX_BITS-1:0]  out_index_q;
	logic                 out_status_q;

	logic [KEY_BITS-1:0]  quot;
	logic [LINK_W-1:0]    link;
	logic                 bkt_we;
	logic [BKT_AW-1:0]    bkt_waddr;
	logic [LINK_W-1:0]    bkt_wdata;

	// exact quotient from the rounded-up reciprocal for every key width that keeps KEY_BITS + BKT_AW below 64
	assign quot = KEY_BITS'(prod_q >> MUL_SH);

	assign link = cmd.link_sel_next ? nnext_q : head_q;

	assign bkt_we    = cmd.sweep | cmd.ins_commit;
	assign bkt_waddr = cmd.sweep ? sweep_q : rem_q;
	assign bkt_wdata = cmd.sweep ? NULL_LINK : nodes_used_q;

	always_comb begin
		stat.mod_done   = (mod_cnt_q == MOD_LAST);
		stat.sweep_last = (sweep_q == BKT_LAST);
		stat.pool_full  = (nodes_used_q >= NULL_LINK);
		stat.is_insert  = (func_q == OP_INSERT);
		stat.link_ok    = (link < NULL_LINK) && (steps_q < NULL_LINK);
		stat.key_hit    = (nkey_q == key_q);
		stat.out_free   = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q    <= '0;
			sweep_q      <= '0;
			nodes_used_q <= '0;
			steps_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				mod_cnt_q <= '0;
				steps_q   <= '0;
			end else begin
				if (cmd.mod_step)
					mod_cnt_q <= mod_cnt_q + MOD_CW'(1);
				if (cmd.node_rd)
					steps_q <= steps_q + LINK_W'(1);
			end
			if (cmd.sweep) begin
				sweep_q      <= stat.sweep_last ? '0 : sweep_q + BKT_AW'(1);
				nodes_used_q <= '0;
			end else if (cmd.ins_commit) begin
				nodes_used_q <= nodes_used_q + LINK_W'(1);
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= req_func;
			key_q        <= req_key;
			rem_q        <= '0;
			res_found_q  <= 1'b0;
			res_index_q  <= '0;
			res_status_q <= 1'b0;
		end else begin
			// hash: product by the reciprocal, quotient times the bucket count, difference
			if (cmd.mod_step) begin
				prod_q <= PROD_W'(key_q) * PROD_W'(RECIP);
				qd_q   <= KEY_BITS'(quot * BKT_C);
				rem_q  <= BKT_AW'(key_q - qd_q);
			end
			if (cmd.res_full)
				res_status_q <= 1'b1;
			if (cmd.ins_commit)
				res_index_q <= IDX_BITS'(nodes_used_q);
			if (cmd.hit) begin
				res_found_q <= 1'b1;
				res_index_q <= IDX_BITS'(cur_q);
			end
		end
		if (cmd.node_rd)
			cur_q <= link[POOL_AW-1:0];
		if (cmd.out_load) begin
			out_found_q  <= res_found_q;
			out_index_q  <= res_index_q;
			out_status_q <= res_status_q;
		end
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (bkt_we)
			bucket_mem[bkt_waddr] <= bkt_wdata;
		if (cmd.head_rd)
			head_q <= bucket_mem[rem_q];
	end

	// node pool memories
	always_ff @(posedge clk) begin
		if (cmd.ins_commit) begin
			key_mem[nodes_used_q[POOL_AW-1:0]]  <= key_q;
			next_mem[nodes_used_q[POOL_AW-1:0]] <= head_q;
		end
		if (cmd.node_rd) begin
			nkey_q  <= key_mem[link[POOL_AW-1:0]];
			nnext_q <= next_mem[link[POOL_AW-1:0]];
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_found      = out_found_q;
	assign rsp_node_index = out_index_q;
	assign rsp_status     = out_status_q;

endmodule

`default_nettype wire

FILE: rtl/chtbl_ctrl.sv
// controller: sequences hash, bucket access, chain walk, clearing sweep and response
`default_nettype none

module chtbl_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [chtbl_pkg::FUNC_BITS-1:0] req_func,
	output logic                            req_ready,
	input  chtbl_pkg::dp_stat_t             stat,
	output chtbl_pkg::dp_cmd_t              cmd
);
	import chtbl_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP_RST,
		S_IDLE,
		S_HASH,
		S_HEAD_RD,
		S_HEAD,
		S_NODE,
		S_SWEEP_CLR,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept    = req_valid & ready_q;
	assign req_ready = ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_SWEEP_RST: cmd.sweep = 1'b1;
			S_SWEEP_CLR: cmd.sweep = 1'b1;
			S_IDLE:      cmd.load = accept;
			S_HASH:      cmd.mod_step = 1'b1;
			S_HEAD_RD: begin
				if (stat.is_insert && stat.pool_full)
					cmd.res_full = 1'b1;
				else
					cmd.head_rd = 1'b1;
			end
			S_HEAD: begin
				if (stat.is_insert)
					cmd.ins_commit = 1'b1;
				else
					cmd.node_rd = stat.link_ok;
			end
			S_NODE: begin
				if (stat.key_hit) begin
					cmd.hit = 1'b1;
				end else begin
					cmd.link_sel_next = 1'b1;
					cmd.node_rd       = stat.link_ok;
				end
			end
			S_RESULT:    cmd.out_load = stat.out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP_RST;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_SWEEP_RST: begin
					if (stat.sweep_last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						if (req_func == OP_INSERT || req_func == OP_SEARCH)
							state_q <= S_HASH;
						else if (req_func == OP_CLEAR)
							state_q <= S_SWEEP_CLR;
						else
							state_q <= S_RESULT;
					end
				end
				S_HASH: begin
					if (stat.mod_done)
						state_q <= S_HEAD_RD;
				end
				S_HEAD_RD: begin
					if (stat.is_insert && stat.pool_full)
						state_q <= S_RESULT;
					else
						state_q <= S_HEAD;
				end
				S_HEAD: begin
					if (stat.is_insert || !stat.link_ok)
						state_q <= S_RESULT;
					else
						state_q <= S_NODE;
				end
				S_NODE: begin
					// stay while the chain continues without a match
					if (stat.key_hit || !stat.link_ok)
						state_q <= S_RESULT;
				end
				S_SWEEP_CLR: begin
					if (stat.sweep_last)
						state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_SWEEP_RST;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/chtbl_checker.sv
// port-level checks for the chained hash table, bound to the top level
`default_nettype none

module chtbl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_found,
	input logic [chtbl_pkg::IDX_BITS-1:0] rsp_node_index,
	input logic                           rsp_status
);

	// a stalled response word stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response valid dropped while stalled");

	// a stalled response word keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_node_index)
			&& $stable(rsp_status))
		else $error("response payload changed while stalled");

	// one word at a time: busy right after taking a request
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// a dropped insert reports neither a hit nor an index
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> !rsp_found && rsp_node_index == '0)
		else $error("pool-full response carries a hit or an index");

endmodule

bind chained_hash_table chtbl_checker u_chtbl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_node_index (rsp.node_index),
	.rsp_status     (rsp.status)
);

`default_nettype wire
